// ===== rtl/bu2x_pkg.sv =====
// Shared constants and types of the 2x bilinear RGBA upscaler.
`timescale 1ns / 1ps
`default_nettype none
package bu2x_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W     = 32;
    localparam int CFG_W     = 12;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int N_SLOTS   = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Result slots, in output raster order.
    localparam int SLOT_CTR  = 0;
    localparam int SLOT_VERT = 1;
    localparam int SLOT_HORZ = 2;
    localparam int SLOT_ORIG = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 1'b0,
        REG_IN_HEIGHT = 1'b1
    } t_cfg_reg;

    // All results one input item produces, with their source position.
    typedef struct packed {
        logic [N_SLOTS-1:0][PIX_W-1:0] pix;
        logic [N_SLOTS-1:0]            mask;
        logic [COL_W-1:0]              col;
        logic [ROW_W-1:0]              row;
    } t_result_set;

endpackage
`default_nettype wire

// ===== rtl/bu2x_interp.sv =====
// Per-channel averaging that forms the up to four results of one input pixel.
`timescale 1ns / 1ps
`default_nettype none
module bu2x_interp (
    input  wire logic [bu2x_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [bu2x_pkg::PIX_W-1:0] i_up,
    input  wire logic [bu2x_pkg::PIX_W-1:0] i_left,
    input  wire logic [bu2x_pkg::PIX_W-1:0] i_upper_left,
    input  wire logic [bu2x_pkg::COL_W-1:0] i_col,
    input  wire logic [bu2x_pkg::ROW_W-1:0] i_row,
    output bu2x_pkg::t_result_set           o_set
);
    import bu2x_pkg::*;

    // Truncating mean of each byte lane.
    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] res;
        logic [8:0]       s;
        res = '0;
        for (int i = 0; i < PIX_W / 8; i++) begin
            s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
            res[8*i +: 8] = s[8:1];
        end
        return res;
    endfunction

    logic [PIX_W-1:0] vl, vr, hu, hd;

    always_comb begin
        vl = avg2(i_upper_left, i_left);
        vr = avg2(i_up, i_pixel);
        hu = avg2(i_upper_left, i_up);
        hd = avg2(i_left, i_pixel);

        o_set.pix[SLOT_CTR]  = avg2(avg2(vl, vr), avg2(hu, hd));
        o_set.pix[SLOT_VERT] = vr;
        o_set.pix[SLOT_HORZ] = hd;
        o_set.pix[SLOT_ORIG] = i_pixel;

        o_set.mask[SLOT_CTR]  = (i_row != '0) && (i_col != '0);
        o_set.mask[SLOT_VERT] = (i_row != '0);
        o_set.mask[SLOT_HORZ] = (i_col != '0);
        o_set.mask[SLOT_ORIG] = 1'b1;

        o_set.col = i_col;
        o_set.row = i_row;
    end

endmodule
`default_nettype wire

// ===== rtl/bu2x_out_buf.sv =====
// Result register that drains one item's result set, one result per cycle while i_out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module bu2x_out_buf (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load_valid,
    input  wire bu2x_pkg::t_result_set        i_load,
    output logic                              o_load_ready,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [bu2x_pkg::PIX_W-1:0]        o_out_pixel,
    output logic [bu2x_pkg::COORD_W-1:0]      o_out_x,
    output logic [bu2x_pkg::COORD_W-1:0]      o_out_y,
    output logic                              o_last
);
    import bu2x_pkg::*;

    t_result_set        r_set;
    logic [N_SLOTS-1:0] r_mask;
    logic [N_SLOTS-1:0] n_mask;
    logic [N_SLOTS-1:0] sel;
    logic [N_SLOTS-1:0] rest;
    logic [COL_W:0]     x_even;
    logic [ROW_W:0]     y_even;
    logic               x_odd, y_odd;
    logic               take;

    // Pick the lowest pending slot.
    always_comb begin
        sel = '0;
        if (r_mask[SLOT_CTR]) begin
            sel[SLOT_CTR] = 1'b1;
        end else if (r_mask[SLOT_VERT]) begin
            sel[SLOT_VERT] = 1'b1;
        end else if (r_mask[SLOT_HORZ]) begin
            sel[SLOT_HORZ] = 1'b1;
        end else begin
            sel[SLOT_ORIG] = 1'b1;
        end
    end

    always_comb begin
        o_out_valid = (r_mask != '0);
        take        = o_out_valid && i_out_ready;
        rest        = r_mask & ~sel;
        o_last      = (rest == '0);

        o_load_ready = !o_out_valid || (take && o_last);

        o_out_pixel = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (sel[i]) begin
                o_out_pixel = r_set.pix[i];
            end
        end

        x_odd  = sel[SLOT_CTR] || sel[SLOT_HORZ];
        y_odd  = sel[SLOT_CTR] || sel[SLOT_VERT];
        x_even = {r_set.col, 1'b0};
        y_even = {r_set.row, 1'b0};
        o_out_x = COORD_W'(x_even - (COL_W + 1)'(x_odd));
        o_out_y = COORD_W'(y_even - (ROW_W + 1)'(y_odd));

        n_mask = r_mask;
        if (take) begin
            n_mask = rest;
        end
        if (i_load_valid && o_load_ready) begin
            n_mask = i_load.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_valid && o_load_ready) begin
            r_set <= i_load;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bilinear_upscale_2x_rgba_unit.sv =====
// Top level of the streaming 2x bilinear RGBA upscaler.
//
// Usage:
//   Feed the pixels of a W x H frame in top-down raster order on the input
//   channel (i_pixel_valid / o_pixel_ready). The block emits the
//   (2W-1) x (2H-1) frame on the result channel (o_out_valid / i_out_ready),
//   each result tagged with its output column and row. Per input item it
//   emits centre, vertical, horizontal and original results, in that order,
//   as far as they exist; o_last marks the final result of an item.
//   The first result of an item passes the input stage and then the result
//   register, once that register is free. An item holds the result register
//   until the last of its results (1 to 4, 4 in the frame interior) has left
//   the single result port, while the input stage holds the next item.
//   The line buffer is one RAM port: read-first read of the pixel above and
//   write of the new pixel in the same cycle.
//   Write in_width / in_height through i_cfg_wr_en only while the block is
//   idle; zero reads as one, values above the maximum saturate.
//   Reset clears counters, neighbor pixels and both pipeline stages and
//   restores 640 x 480; the line buffer needs no clearing.
//   When the receiver stalls, the current result holds, the stage behind it
//   fills, and then o_pixel_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_upscale_2x_rgba_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bu2x_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bu2x_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_pixel_valid,
    output logic                                o_pixel_ready,
    input  wire logic [bu2x_pkg::PIX_W-1:0]     i_pixel,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [bu2x_pkg::PIX_W-1:0]          o_out_pixel,
    output logic [bu2x_pkg::COORD_W-1:0]        o_out_x,
    output logic [bu2x_pkg::COORD_W-1:0]        o_out_y,
    output logic                                o_last
);
    import bu2x_pkg::*;

    // Configuration
    logic [CFG_W-1:0] r_in_width;
    logic [CFG_W-1:0] r_in_height;
    logic [COL_W:0]   w_lim;
    logic [ROW_W:0]   h_lim;

    // Raster position of the next item
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    // Line buffer holding the previous row
    logic [PIX_W-1:0] r_line [MAX_WIDTH];
    logic [PIX_W-1:0] r_up;

    // Input stage
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_pixel;
    logic [COL_W-1:0] r_a_col;
    logic [ROW_W-1:0] r_a_row;

    // Neighbors of the item in the input stage
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upper_left;

    logic        accept;
    logic        a_advance;
    logic        buf_ready;
    t_result_set set;

    // Clamp the frame size: zero means one, saturate at the maximum.
    always_comb begin
        int w_int;
        int h_int;
        w_int = int'(r_in_width);
        h_int = int'(r_in_height);
        if (w_int == 0) begin
            w_int = 1;
        end else if (w_int > MAX_WIDTH) begin
            w_int = MAX_WIDTH;
        end
        if (h_int == 0) begin
            h_int = 1;
        end else if (h_int > MAX_HEIGHT) begin
            h_int = MAX_HEIGHT;
        end
        w_lim = (COL_W + 1)'(w_int);
        h_lim = (ROW_W + 1)'(h_int);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= WIDTH_RESET;
            r_in_height <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_IN_WIDTH:  r_in_width  <= i_cfg_data;
                REG_IN_HEIGHT: r_in_height <= i_cfg_data;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the result register
    // takes its set, so a new item can enter in the same cycle.
    always_comb begin
        a_advance     = r_a_valid && buf_ready;
        o_pixel_ready = !r_a_valid || a_advance;
        accept        = i_pixel_valid && o_pixel_ready;
    end

    // Advance the raster position; wrap at row and frame end.
    always_comb begin
        col_inc = {1'b0, r_col} + (COL_W + 1)'(1);
        row_inc = {1'b0, r_row} + (ROW_W + 1)'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (accept) begin
            if (col_inc >= w_lim) begin
                n_col = '0;
                n_row = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_advance) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Read the pixel above and store the new one at the same column.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up         <= r_line[r_col];
            r_line[r_col] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pixel <= i_pixel;
            r_a_col   <= r_col;
            r_a_row   <= r_row;
        end
    end

    // Shift the neighbor window as the item leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
        end else if (a_advance) begin
            r_left       <= r_a_pixel;
            r_upper_left <= r_up;
        end
    end

    bu2x_interp u_interp (
        .i_pixel      (r_a_pixel),
        .i_up         (r_up),
        .i_left       (r_left),
        .i_upper_left (r_upper_left),
        .i_col        (r_a_col),
        .i_row        (r_a_row),
        .o_set        (set)
    );

    bu2x_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_a_valid),
        .i_load       (set),
        .o_load_ready (buf_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_pixel  (o_out_pixel),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
